// File: rtl/core/pqae_pkg.sv
// ----------------------------------------------------------------------------
// pqae_pkg
// Shared types, widths and codes of the priority queue with age expiry.
// ----------------------------------------------------------------------------
package pqae_pkg;

  // Queue geometry and result budget per tick
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DIV_W       = $clog2(MAX_RESULTS);

  // Field widths
  localparam int unsigned PRI_W  = 4;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned HOUR_W = 8;

  // Reset values
  localparam logic [HOUR_W-1:0] HOUR_RESET     = HOUR_W'(1);
  localparam logic [HOUR_W-1:0] MAX_WAIT_RESET = HOUR_W'(3);

  // Register port
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam logic        REG_MAX_WAIT = 1'b0;  // word index of max_wait

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_SERVED   = 2'd0,
    KIND_DIVERTED = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_e;

  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [TAG_W-1:0]  tag;
    logic [HOUR_W-1:0] arr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    kind_e             kind;
    logic [PRI_W-1:0]  pri;
    logic [TAG_W-1:0]  tag;
    logic [HOUR_W-1:0] arr;
    logic [HOUR_W-1:0] ev;
    logic              last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJ,
    ST_INS_CMP,
    ST_INS_NEW,
    ST_TK_HEAD,
    ST_TK_SCAN,
    ST_TK_SERVE
  } state_e;

endpackage

// File: rtl/core/pqae_ram.sv
// ----------------------------------------------------------------------------
// pqae_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pqae_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 28,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/core/pqae_regs.sv
// ----------------------------------------------------------------------------
// pqae_regs
// APB register slice holding the max_wait expiry threshold.
// ----------------------------------------------------------------------------
module pqae_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pqae_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pqae_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pqae_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [pqae_pkg::HOUR_W-1:0]      max_wait_o
);
  import pqae_pkg::*;

  logic              wr_en;
  logic              sel_max_wait;
  logic [HOUR_W-1:0] max_wait_q, max_wait_d;

  // Decode the word index; byte offset bits are ignored
  assign sel_max_wait = (paddr[APB_ADDR_W-1] == REG_MAX_WAIT);
  assign wr_en        = psel && penable && pwrite;

  always_comb begin
    max_wait_d = max_wait_q;
    if (wr_en && sel_max_wait) begin
      max_wait_d = pwdata[HOUR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wait_q <= MAX_WAIT_RESET;
    end else begin
      max_wait_q <= max_wait_d;
    end
  end

  // Read back, zero outside the register list
  assign prdata     = sel_max_wait ? APB_DATA_W'(max_wait_q) : '0;
  assign pready     = 1'b1;
  assign max_wait_o = max_wait_q;

endmodule

// File: rtl/core/pqae_out.sv
// ----------------------------------------------------------------------------
// pqae_out
// Output register: holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module pqae_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pqae_pkg::res_t  res_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pqae_pkg::res_t  res_o
);
  import pqae_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // Slot is free when empty or drained this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/core/pqae_ctrl.sv
// ----------------------------------------------------------------------------
// pqae_ctrl
// Sequencer for the sorted entry memory: insert by shifting entries up from
// the tail, tick by reading the head, then scanning and compacting the rest.
// ----------------------------------------------------------------------------
module pqae_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [pqae_pkg::PRI_W-1:0]    priority_req_i,
  input  logic [pqae_pkg::TAG_W-1:0]    tag_i,
  input  logic [pqae_pkg::HOUR_W-1:0]   max_wait_i,
  output pqae_pkg::ram_req_t            ram_req_o,
  input  pqae_pkg::entry_t              ram_rdata_i,
  output logic                          res_push_o,
  output pqae_pkg::res_t                res_o,
  input  logic                          out_free_i
);
  import pqae_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [HOUR_W-1:0] hour_q, hour_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  wr_q, wr_d;
  logic [DIV_W-1:0]  ndiv_q, ndiv_d;
  logic [PRI_W-1:0]  op_pri_q, op_pri_d;
  logic [TAG_W-1:0]  op_tag_q, op_tag_d;
  entry_t            head_q, head_d;

  logic              accept;
  logic              is_insert;
  logic              full;
  logic              shift_up;
  logic              expired;
  logic              scan_step;
  logic              scan_more;
  logic [HOUR_W-1:0] age;
  logic [HOUR_W-1:0] hour_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W-1:0]  idx_dec2;
  logic [CNT_W-1:0]  idx_inc;
  entry_t            new_entry;

  // Shared decisions
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_insert  = (opcode_i == OP_INSERT);
  assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign cnt_dec    = cnt_q - CNT_W'(1);
  assign idx_dec    = idx_q - CNT_W'(1);
  assign idx_dec2   = idx_q - CNT_W'(2);
  assign idx_inc    = idx_q + CNT_W'(1);
  assign hour_inc   = hour_q + HOUR_W'(1);
  assign age        = hour_q - ram_rdata_i.arr;
  assign shift_up   = (ram_rdata_i.pri > op_pri_q);
  assign expired    = (age >= max_wait_i) && (ndiv_q != DIV_W'(MAX_RESULTS - 1));
  assign scan_step  = !expired || out_free_i;
  assign scan_more  = (idx_inc < cnt_q);
  assign new_entry  = '{pri: op_pri_q, tag: op_tag_q, arr: hour_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            if (full) begin
              state_d = ST_REJ;
            end else if (cnt_q == '0) begin
              state_d = ST_INS_NEW;
            end else begin
              state_d = ST_INS_CMP;
            end
          end else if (cnt_q != '0) begin
            state_d = ST_TK_HEAD;
          end
        end
      end
      ST_REJ: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_INS_CMP: begin
        if (!shift_up) begin
          state_d = ST_IDLE;
        end else if (idx_q == CNT_W'(1)) begin
          state_d = ST_INS_NEW;
        end
      end
      ST_INS_NEW: begin
        state_d = ST_IDLE;
      end
      ST_TK_HEAD: begin
        state_d = (cnt_q > CNT_W'(1)) ? ST_TK_SCAN : ST_TK_SERVE;
      end
      ST_TK_SCAN: begin
        if (scan_step && !scan_more) begin
          state_d = ST_TK_SERVE;
        end
      end
      ST_TK_SERVE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory requests and result pushes
  always_comb begin
    cnt_d      = cnt_q;
    hour_d     = hour_q;
    idx_d      = idx_q;
    wr_d       = wr_q;
    ndiv_d     = ndiv_q;
    op_pri_d   = op_pri_q;
    op_tag_d   = op_tag_q;
    head_d     = head_q;
    ram_req_o  = '0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_pri_d = priority_req_i;
          op_tag_d = tag_i;
          wr_d     = '0;
          ndiv_d   = '0;
          if (is_insert) begin
            // Start the tail-to-head walk at the last entry
            idx_d = cnt_q;
            if (!full && cnt_q != '0) begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = cnt_dec[IDX_W-1:0];
            end
          end else if (cnt_q == '0) begin
            hour_d = hour_inc;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = '0;
          end
        end
      end
      ST_REJ: begin
        res_o      = '{kind: KIND_REJECTED, pri: op_pri_q, tag: op_tag_q,
                       arr: hour_q, ev: hour_q, last: 1'b1};
        res_push_o = out_free_i;
      end
      ST_INS_CMP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[IDX_W-1:0];
        if (shift_up) begin
          // Move the larger entry up one slot, fetch the next one down
          ram_req_o.wdata = ram_rdata_i;
          idx_d           = idx_dec;
          if (idx_q != CNT_W'(1)) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = idx_dec2[IDX_W-1:0];
          end
        end else begin
          ram_req_o.wdata = new_entry;
          cnt_d           = cnt_q + CNT_W'(1);
        end
      end
      ST_INS_NEW: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[IDX_W-1:0];
        ram_req_o.wdata = new_entry;
        cnt_d           = cnt_q + CNT_W'(1);
      end
      ST_TK_HEAD: begin
        // Hold the head aside; survivors compact from slot zero
        head_d = ram_rdata_i;
        idx_d  = CNT_W'(1);
        if (cnt_q > CNT_W'(1)) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = IDX_W'(1);
        end
      end
      ST_TK_SCAN: begin
        if (expired) begin
          res_o      = '{kind: KIND_DIVERTED, pri: ram_rdata_i.pri, tag: ram_rdata_i.tag,
                         arr: ram_rdata_i.arr, ev: hour_q, last: 1'b0};
          res_push_o = out_free_i;
          if (out_free_i) begin
            ndiv_d = ndiv_q + DIV_W'(1);
          end
        end else begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = wr_q[IDX_W-1:0];
          ram_req_o.wdata = ram_rdata_i;
          wr_d            = wr_q + CNT_W'(1);
        end
        if (scan_step) begin
          idx_d = idx_inc;
          if (scan_more) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = idx_inc[IDX_W-1:0];
          end
        end
      end
      ST_TK_SERVE: begin
        res_o      = '{kind: KIND_SERVED, pri: head_q.pri, tag: head_q.tag,
                       arr: head_q.arr, ev: hour_inc, last: 1'b1};
        res_push_o = out_free_i;
        if (out_free_i) begin
          cnt_d  = wr_q;
          hour_d = hour_inc;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      hour_q  <= HOUR_RESET;
      idx_q   <= '0;
      wr_q    <= '0;
      ndiv_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hour_q  <= hour_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      ndiv_q  <= ndiv_d;
    end
  end

  // Operand and head holding registers
  always_ff @(posedge clk_i) begin
    op_pri_q <= op_pri_d;
    op_tag_q <= op_tag_d;
    head_q   <= head_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req_o.we && ram_req_o.re) |-> (ram_req_o.waddr != ram_req_o.raddr))
    else $error("read and write to the same slot in one cycle");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> out_free_i)
    else $error("result pushed into a full output register");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TK_SCAN) |-> (wr_q < idx_q))
    else $error("compaction write pointer caught up with scan pointer");

  a_serve_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.kind == KIND_SERVED) |=> (state_q == ST_IDLE))
    else $error("tick did not finish after serving the head");
`endif

endmodule

// File: rtl/core/priority_queue_with_age_expiry.sv
// Insert shifts larger entries up from the tail; a reject waits on output stalls.
// Tick: empty queue just advances the hour; else output stalls hold it, and the single
// entry memory read port walks one entry per cycle unless a diverted result stalls.
// Each result reaches the output register in the cycle after it is produced.
// Reset clears the entry count, sets the hour to 1 and max_wait to 3.
// ----------------------------------------------------------------------------
// priority_queue_with_age_expiry
// Sorted priority queue in a one-port-read RAM, with age expiry on each tick.
// ----------------------------------------------------------------------------
module priority_queue_with_age_expiry (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Item input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic [pqae_pkg::PRI_W-1:0]       priority_req_i,
  input  logic [pqae_pkg::TAG_W-1:0]       tag_i,
  // Result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       kind_o,
  output logic [pqae_pkg::PRI_W-1:0]       out_priority_o,
  output logic [pqae_pkg::TAG_W-1:0]       out_tag_o,
  output logic [pqae_pkg::HOUR_W-1:0]      arrival_hour_o,
  output logic [pqae_pkg::HOUR_W-1:0]      event_hour_o,
  output logic                             last_o,
  // Register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pqae_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pqae_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pqae_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import pqae_pkg::*;

  logic [HOUR_W-1:0]  max_wait;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_push;
  logic               out_free;
  res_t               res;
  res_t               res_out;

  pqae_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_wait_o (max_wait)
  );

  pqae_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  pqae_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .priority_req_i (priority_req_i),
    .tag_i          (tag_i),
    .max_wait_i     (max_wait),
    .ram_req_o      (ram_req),
    .ram_rdata_i    (ram_rdata),
    .res_push_o     (res_push),
    .res_o          (res),
    .out_free_i     (out_free)
  );

  pqae_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  // Unpack the result onto the field ports
  assign kind_o         = res_out.kind;
  assign out_priority_o = res_out.pri;
  assign out_tag_o      = res_out.tag;
  assign arrival_hour_o = res_out.arr;
  assign event_hour_o   = res_out.ev;
  assign last_o         = res_out.last;

endmodule
